FILE: sv/slab_slot_allocator_macros.svh
// Assertion macros for the slab slot allocator.
// Used by the top level; no dependencies.
`ifndef SLAB_SLOT_ALLOCATOR_MACROS_SVH
`define SLAB_SLOT_ALLOCATOR_MACROS_SVH

`ifndef SYNTH
`define SSA_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("slab_slot_allocator: same-cycle check failed");
`define SSA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("slab_slot_allocator: next-cycle check failed");
`else
`define SSA_ASSERT_SAME(name, clk, rstn, ante, cons)
`define SSA_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/ssa_pkg.sv
// Types, constants and codes of the slab slot allocator.
// No dependencies.
package ssa_pkg;

    localparam int SLOTS_PER_SLAB = 32;
    localparam int MAX_SLABS      = 16;

    localparam int SLOT_W      = $clog2(SLOTS_PER_SLAB);
    localparam int SLAB_W      = $clog2(MAX_SLABS);
    localparam int CNT_W       = $clog2(SLOTS_PER_SLAB + 1);
    localparam int MADE_W      = $clog2(MAX_SLABS + 1);
    localparam int STACK_DEPTH = MAX_SLABS * SLOTS_PER_SLAB;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_FULL        = 2'd1;
    localparam logic [1:0] STATUS_BAD_RELEASE = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [SLAB_W-1:0] rel_slab;
        logic [SLOT_W-1:0] rel_slot;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLAB_W-1:0] got_slab;
        logic [SLOT_W-1:0] got_slot;
    } out_item_t;

    // free count and low-water mark of the count since the slab was made
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] lw;
    } cnt_entry_t;

    typedef struct packed {
        logic              en;
        logic              kind;
        logic              make;
        logic [SLAB_W-1:0] slab;
        logic              nonempty;
    } hint_upd_t;

    typedef struct packed {
        logic [MADE_W-1:0] slabs_made;
        logic              use_hint;
        logic [SLAB_W-1:0] hint_slab;
    } hint_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_STACK,
        ST_DONE
    } state_t;

endpackage

FILE: sv/ssa_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/ssa_hint.sv
// Slab bookkeeping: created-slab count, per-slab nonempty flags and the hint.
// Depends on ssa_pkg.
module ssa_hint (
    input  logic               aclk,
    input  logic               aresetn,
    input  ssa_pkg::hint_upd_t upd,
    output ssa_pkg::hint_stat_t stat
);

    logic [ssa_pkg::MAX_SLABS-1:0] nonempty_reg, nonempty_next;
    logic [ssa_pkg::MADE_W-1:0]    made_reg, made_next;
    logic                          hint_valid_reg, hint_valid_next;
    logic [ssa_pkg::SLAB_W-1:0]    hint_slab_reg, hint_slab_next;

    logic [ssa_pkg::MAX_SLABS-1:0] cand;
    logic                          found;
    logic [ssa_pkg::SLAB_W-1:0]    found_slab;

    // lowest nonempty slab above the one just emptied
    always_comb begin
        found      = 1'b0;
        found_slab = '0;
        for (int i = 0; i < ssa_pkg::MAX_SLABS; i++) begin
            cand[i] = nonempty_reg[i] && (ssa_pkg::SLAB_W'(i) > upd.slab);
        end
        for (int i = ssa_pkg::MAX_SLABS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found      = 1'b1;
                found_slab = ssa_pkg::SLAB_W'(i);
            end
        end
    end

    always_comb begin
        nonempty_next   = nonempty_reg;
        made_next       = made_reg;
        hint_valid_next = hint_valid_reg;
        hint_slab_next  = hint_slab_reg;
        if (upd.en) begin
            nonempty_next[upd.slab] = upd.nonempty;
            if (upd.make) begin
                made_next = made_reg + ssa_pkg::MADE_W'(1);
            end
            if (upd.kind == ssa_pkg::KIND_ALLOC) begin
                if (upd.make) begin
                    hint_valid_next = 1'b1;
                    hint_slab_next  = upd.slab;
                end
                if (!upd.nonempty) begin
                    hint_valid_next = found;
                    if (found) begin
                        hint_slab_next = found_slab;
                    end
                end
            end else if (!hint_valid_reg || (upd.slab < hint_slab_reg)) begin
                hint_valid_next = 1'b1;
                hint_slab_next  = upd.slab;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg   <= '0;
            made_reg       <= '0;
            hint_valid_reg <= 1'b0;
            hint_slab_reg  <= '0;
        end else begin
            nonempty_reg   <= nonempty_next;
            made_reg       <= made_next;
            hint_valid_reg <= hint_valid_next;
            hint_slab_reg  <= hint_slab_next;
        end
    end

    assign stat.slabs_made = made_reg;
    assign stat.use_hint   = hint_valid_reg && nonempty_reg[hint_slab_reg];
    assign stat.hint_slab  = hint_slab_reg;

endmodule

FILE: sv/slab_slot_allocator.sv
// Slab slot allocator: one request at a time through count and stack RAMs.
// An allocate steps through COUNT (read-modify-write of the count RAM), then
// STACK (stack RAM read), then DONE; a release goes through COUNT to DONE, and
// pool full or a release to an uncreated slab goes straight to DONE. A new
// transfer is taken the cycle after DONE loads the result once the output is free.
// Reset is synchronous; no clearing pass, the block takes transfers at once.
// Depends on ssa_pkg, ssa_ram, ssa_hint and slab_slot_allocator_macros.svh.
`include "slab_slot_allocator_macros.svh"

module slab_slot_allocator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ssa_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ssa_pkg::out_item_t m_item
);

    ssa_pkg::state_t    state_reg, state_next;
    ssa_pkg::in_item_t  req_reg, req_next;
    logic [ssa_pkg::SLAB_W-1:0] slab_reg, slab_next;
    logic               make_reg, make_next;
    logic [ssa_pkg::SLOT_W-1:0] top_reg, top_next;
    logic               seed_reg, seed_next;
    ssa_pkg::out_item_t res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    ssa_pkg::out_item_t m_item_reg, m_item_next;

    logic                               cnt_rd_en;
    logic [ssa_pkg::SLAB_W-1:0]         cnt_rd_addr;
    ssa_pkg::cnt_entry_t                cnt_rd_data;
    logic                               cnt_wr_en;
    logic [ssa_pkg::SLAB_W-1:0]         cnt_wr_addr;
    ssa_pkg::cnt_entry_t                cnt_wr_data;
    logic                               stk_rd_en;
    logic [ssa_pkg::SLAB_W+ssa_pkg::SLOT_W-1:0] stk_rd_addr;
    logic [ssa_pkg::SLOT_W-1:0]         stk_rd_data;
    logic                               stk_wr_en;
    logic [ssa_pkg::SLAB_W+ssa_pkg::SLOT_W-1:0] stk_wr_addr;
    logic [ssa_pkg::SLOT_W-1:0]         stk_wr_data;

    ssa_pkg::hint_upd_t  hint_upd;
    ssa_pkg::hint_stat_t hint_stat;

    logic                       in_xfer;
    logic                       out_free;
    logic                       pool_full;
    logic                       rel_known;
    logic                       idle_to_count;
    ssa_pkg::cnt_entry_t        cnt_cur;
    logic [ssa_pkg::CNT_W-1:0]  cnt_top;
    logic                       rel_full;

    ssa_ram #(
        .WIDTH($bits(ssa_pkg::cnt_entry_t)),
        .DEPTH(ssa_pkg::MAX_SLABS)
    ) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_en   (cnt_rd_en),
        .rd_addr (cnt_rd_addr),
        .rd_data (cnt_rd_data)
    );

    ssa_ram #(
        .WIDTH(ssa_pkg::SLOT_W),
        .DEPTH(ssa_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_wr_en),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd_en),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    ssa_hint u_hint (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (hint_upd),
        .stat    (hint_stat)
    );

    assign s_ready  = (state_reg == ssa_pkg::ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    assign pool_full = hint_stat.slabs_made >= ssa_pkg::MADE_W'(ssa_pkg::MAX_SLABS);
    assign rel_known = ssa_pkg::MADE_W'(s_item.rel_slab) < hint_stat.slabs_made;
    assign idle_to_count = (s_item.kind == ssa_pkg::KIND_ALLOC)
                         ? (hint_stat.use_hint || !pool_full) : rel_known;

    // a freshly made slab holds its full seed; its stack is not written when it is made
    assign cnt_cur = make_reg
                   ? '{cnt: ssa_pkg::CNT_W'(ssa_pkg::SLOTS_PER_SLAB),
                       lw:  ssa_pkg::CNT_W'(ssa_pkg::SLOTS_PER_SLAB)}
                   : cnt_rd_data;
    assign cnt_top  = cnt_cur.cnt - ssa_pkg::CNT_W'(1);
    assign rel_full = cnt_cur.cnt >= ssa_pkg::CNT_W'(ssa_pkg::SLOTS_PER_SLAB);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ssa_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = idle_to_count ? ssa_pkg::ST_COUNT : ssa_pkg::ST_DONE;
                end
            end
            ssa_pkg::ST_COUNT: begin
                state_next = (req_reg.kind == ssa_pkg::KIND_ALLOC)
                           ? ssa_pkg::ST_STACK : ssa_pkg::ST_DONE;
            end
            ssa_pkg::ST_STACK: begin
                state_next = ssa_pkg::ST_DONE;
            end
            ssa_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ssa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        req_next     = req_reg;
        slab_next    = slab_reg;
        make_next    = make_reg;
        top_next     = top_reg;
        seed_next    = seed_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        cnt_rd_en    = 1'b0;
        cnt_rd_addr  = '0;
        cnt_wr_en    = 1'b0;
        cnt_wr_addr  = slab_reg;
        cnt_wr_data  = '0;
        stk_rd_en    = 1'b0;
        stk_rd_addr  = {slab_reg, cnt_top[ssa_pkg::SLOT_W-1:0]};
        stk_wr_en    = 1'b0;
        stk_wr_addr  = {slab_reg, cnt_cur.cnt[ssa_pkg::SLOT_W-1:0]};
        stk_wr_data  = req_reg.rel_slot;
        hint_upd     = '0;
        unique case (state_reg)
            ssa_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    req_next  = s_item;
                    res_next  = '0;
                    make_next = 1'b0;
                    if (s_item.kind == ssa_pkg::KIND_ALLOC) begin
                        if (hint_stat.use_hint) begin
                            slab_next   = hint_stat.hint_slab;
                            cnt_rd_en   = 1'b1;
                            cnt_rd_addr = hint_stat.hint_slab;
                        end else if (pool_full) begin
                            res_next.status = ssa_pkg::STATUS_FULL;
                        end else begin
                            slab_next = hint_stat.slabs_made[ssa_pkg::SLAB_W-1:0];
                            make_next = 1'b1;
                        end
                    end else begin
                        slab_next   = s_item.rel_slab;
                        cnt_rd_en   = rel_known;
                        cnt_rd_addr = s_item.rel_slab;
                        if (!rel_known) begin
                            res_next.status = ssa_pkg::STATUS_BAD_RELEASE;
                        end
                    end
                end
            end
            ssa_pkg::ST_COUNT: begin
                if (req_reg.kind == ssa_pkg::KIND_ALLOC) begin
                    cnt_wr_en         = 1'b1;
                    cnt_wr_data.cnt   = cnt_top;
                    cnt_wr_data.lw    = (cnt_cur.lw < cnt_top) ? cnt_cur.lw : cnt_top;
                    stk_rd_en         = 1'b1;
                    top_next          = cnt_top[ssa_pkg::SLOT_W-1:0];
                    // entry still holds its seed if the count never fell this low
                    seed_next         = cnt_cur.lw > cnt_top;
                    hint_upd.en       = 1'b1;
                    hint_upd.kind     = ssa_pkg::KIND_ALLOC;
                    hint_upd.make     = make_reg;
                    hint_upd.slab     = slab_reg;
                    hint_upd.nonempty = (cnt_top != '0);
                end else if (rel_full) begin
                    res_next.status = ssa_pkg::STATUS_BAD_RELEASE;
                end else begin
                    stk_wr_en         = 1'b1;
                    cnt_wr_en         = 1'b1;
                    cnt_wr_data.cnt   = cnt_cur.cnt + ssa_pkg::CNT_W'(1);
                    cnt_wr_data.lw    = cnt_cur.lw;
                    hint_upd.en       = 1'b1;
                    hint_upd.kind     = ssa_pkg::KIND_RELEASE;
                    hint_upd.slab     = slab_reg;
                    hint_upd.nonempty = 1'b1;
                end
            end
            ssa_pkg::ST_STACK: begin
                res_next.got_slab = slab_reg;
                res_next.got_slot = seed_reg
                                  ? ssa_pkg::SLOT_W'(ssa_pkg::SLOTS_PER_SLAB - 1) - top_reg
                                  : stk_rd_data;
            end
            ssa_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_item_next  = res_reg;
                end
            end
            default: begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ssa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        slab_reg   <= slab_next;
        make_reg   <= make_next;
        top_reg    <= top_next;
        seed_reg   <= seed_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    `SSA_ASSERT_NEXT(a_xfer_leaves_idle, aclk, aresetn, in_xfer, state_reg != ssa_pkg::ST_IDLE)
    `SSA_ASSERT_NEXT(a_done_holds_on_stall, aclk, aresetn, (state_reg == ssa_pkg::ST_DONE) && m_valid_reg && !m_ready, state_reg == ssa_pkg::ST_DONE)
    `SSA_ASSERT_SAME(a_pop_from_nonempty, aclk, aresetn, (state_reg == ssa_pkg::ST_COUNT) && (req_reg.kind == ssa_pkg::KIND_ALLOC), cnt_cur.cnt != '0)
    `SSA_ASSERT_SAME(a_slabs_in_range, aclk, aresetn, 1'b1, hint_stat.slabs_made <= ssa_pkg::MADE_W'(ssa_pkg::MAX_SLABS))

endmodule
